FILE: design/erp_pkg.sv
// shared types, constants and tables for the euler point rotator
`default_nettype none
package erp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int ITER_W = $clog2(ATAN_ENTRIES);

  // register indexes of the configuration port
  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  localparam int ANGLE_W = 16;
  localparam int COORD_W = 32;
  localparam int COEF_W = 18;
  localparam int POINT_W = 3 * COORD_W;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // cordic angle in q.30, with headroom for the unreduced value
  typedef logic signed [34:0] zang_t;
  typedef logic signed [33:0] cvec_t;

  localparam zang_t PI_Q30 = 35'sd3373259426;
  localparam zang_t HALF_PI_Q30 = 35'sd1686629713;
  localparam zang_t TWO_PI_Q30 = 35'sd6746518852;
  localparam cvec_t GAIN_Q30 = 34'sd652032874;

  // control from the coefficient builder to the input side
  typedef struct packed {
    logic busy;
  } build_stat_t;

  // arctangent table in q.30
  function automatic zang_t atan_q30(input logic [ITER_W-1:0] i);
    unique case (i)
      5'd0: atan_q30 = 35'sh03243F6A8;
      5'd1: atan_q30 = 35'sh01DAC6705;
      5'd2: atan_q30 = 35'sh00FADBAFC;
      5'd3: atan_q30 = 35'sh007F56EA6;
      5'd4: atan_q30 = 35'sh003FEAB76;
      5'd5: atan_q30 = 35'sh001FFD55B;
      5'd6: atan_q30 = 35'sh000FFFAAA;
      5'd7: atan_q30 = 35'sh0007FFF55;
      5'd8: atan_q30 = 35'sh0003FFFEA;
      5'd9: atan_q30 = 35'sh0001FFFFD;
      5'd10: atan_q30 = 35'sh0000FFFFF;
      5'd11: atan_q30 = 35'sh00007FFFF;
      5'd12: atan_q30 = 35'sh00003FFFF;
      5'd13: atan_q30 = 35'sh00001FFFF;
      5'd14: atan_q30 = 35'sh00000FFFF;
      5'd15: atan_q30 = 35'sh000007FFF;
      5'd16: atan_q30 = 35'sh000003FFF;
      5'd17: atan_q30 = 35'sh000001FFF;
      5'd18: atan_q30 = 35'sh000000FFF;
      5'd19: atan_q30 = 35'sh0000007FF;
      5'd20: atan_q30 = 35'sh0000003FF;
      5'd21: atan_q30 = 35'sh0000001FF;
      5'd22: atan_q30 = 35'sh0000000FF;
      5'd23: atan_q30 = 35'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: design/euler_rotate_point_3d.sv
// top level of the euler point rotator
//
// channel  direction  handshake                  payload
// s_axis   in         s_axis_tvalid/tready       point x, y, z (q16.16)
// m_axis   out        m_axis_tvalid/tready       rotated x, y, z (q16.16, saturated)
// cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data (angle q3.12)
//
// one point per cycle sustained while the output is not stalled and no rebuild runs;
// from acceptance to output a point passes the queue, product and output registers
// an angle write starts a rebuild of the matrix: per axis the single cordic unit
// runs LOAD, FOLD, ITER and FIN, then the products run on one shared multiplier;
// s_axis_tready is low meanwhile
// reset (rst, synchronous) loads the identity matrix and zero angles
// an output stall fills the two-entry queue before s_axis_tready drops
`default_nettype none
module euler_rotate_point_3d (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // point_x, point_y, point_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // rotated_x, rotated_y, rotated_z
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  erp_pkg::build_stat_t stat;
  erp_pkg::coef_t coef [9];
  logic q_valid, q_ready;
  logic [erp_pkg::POINT_W-1:0] q_data;

  assign cfg_ready = 1'b1;

  erp_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .stat     (stat),
    .coef     (coef)
  );

  erp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  erp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: design/erp_coef.sv
// angle registers, cordic sine/cosine and sequential matrix coefficient builder
`default_nettype none
module erp_coef (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [1:0]              wr_index,
  input  wire logic [15:0]             wr_data,
  output erp_pkg::build_stat_t         stat,
  output erp_pkg::coef_t               coef [9]
);

  typedef enum logic [2:0] {IDLE, LOAD, FOLD, ITER, FIN, MUL, WB, SAT} state_t;
  typedef enum logic [3:0] {O_SX, O_CX, O_SY, O_CY, O_SZ, O_CZ, O_TA, O_TG, O_TJ} opnd_t;
  typedef enum logic [2:0] {OP_SET, OP_NSET, OP_ADD, OP_SUB, OP_TMP} mop_t;
  typedef struct packed {
    opnd_t      a;
    opnd_t      b;
    logic [3:0] dst;
    mop_t       op;
  } ustep_t;

  localparam logic [3:0] LAST_STEP = 4'd14;

  // product sequence for the nine coefficients
  function automatic ustep_t ucode(input logic [3:0] s);
    unique case (s)
      4'd0: ucode = '{O_CY, O_CZ, 4'd0, OP_SET};
      4'd1: ucode = '{O_SZ, O_CY, 4'd1, OP_NSET};
      4'd2: ucode = '{O_SX, O_SY, 4'd0, OP_TMP};
      4'd3: ucode = '{O_TA, O_CZ, 4'd3, OP_SET};
      4'd4: ucode = '{O_SZ, O_CX, 4'd3, OP_ADD};
      4'd5: ucode = '{O_TA, O_SZ, 4'd4, OP_NSET};
      4'd6: ucode = '{O_CX, O_CZ, 4'd4, OP_ADD};
      4'd7: ucode = '{O_SX, O_CY, 4'd5, OP_NSET};
      4'd8: ucode = '{O_SX, O_SZ, 4'd6, OP_SET};
      4'd9: ucode = '{O_SY, O_CX, 4'd1, OP_TMP};
      4'd10: ucode = '{O_TG, O_CZ, 4'd6, OP_SUB};
      4'd11: ucode = '{O_SX, O_CZ, 4'd7, OP_SET};
      4'd12: ucode = '{O_SY, O_SZ, 4'd2, OP_TMP};
      4'd13: ucode = '{O_TJ, O_CX, 4'd7, OP_ADD};
      4'd14: ucode = '{O_CX, O_CY, 4'd8, OP_SET};
      default: ucode = '{O_SX, O_SX, 4'd0, OP_TMP};
    endcase
  endfunction

  state_t state;
  erp_pkg::angle_t ang [3];
  logic [1:0] k;
  logic [erp_pkg::ITER_W-1:0] it;
  logic [3:0] step;
  erp_pkg::zang_t z;
  erp_pkg::cvec_t x, y;
  logic neg;
  erp_pkg::coef_t sx, cx, sy, cy, sz, cz, ta, tg, tj;
  logic signed [35:0] prod;
  logic signed [19:0] macc [9];

  erp_pkg::angle_t ang_sel;
  erp_pkg::zang_t z_wide, z_red;
  erp_pkg::cvec_t xs, ys, xf, yf;
  logic signed [19:0] cos_r, sin_r, mq;
  ustep_t us;
  erp_pkg::coef_t opa, opb;

  function automatic erp_pkg::coef_t pick(input opnd_t o, input erp_pkg::coef_t s_x,
      input erp_pkg::coef_t c_x, input erp_pkg::coef_t s_y, input erp_pkg::coef_t c_y,
      input erp_pkg::coef_t s_z, input erp_pkg::coef_t c_z, input erp_pkg::coef_t t_a,
      input erp_pkg::coef_t t_g, input erp_pkg::coef_t t_j);
    unique case (o)
      O_SX: pick = s_x;
      O_CX: pick = c_x;
      O_SY: pick = s_y;
      O_CY: pick = c_y;
      O_SZ: pick = s_z;
      O_CZ: pick = c_z;
      O_TA: pick = t_a;
      O_TG: pick = t_g;
      O_TJ: pick = t_j;
      default: pick = '0;
    endcase
  endfunction

  function automatic erp_pkg::coef_t sat_coef(input logic signed [19:0] v);
    if (v > 20'sd131071) sat_coef = 18'sd131071;
    else if (v < -20'sd131072) sat_coef = -18'sd131072;
    else sat_coef = v[17:0];
  endfunction

  // angle select, widening and one-step wrap into [-pi, pi]
  always_comb begin
    unique case (k)
      2'd0: ang_sel = ang[0];
      2'd1: ang_sel = ang[1];
      default: ang_sel = ang[2];
    endcase
    z_wide = {ang_sel[15], ang_sel, 18'b0};
    if (z_wide > erp_pkg::PI_Q30) z_red = z_wide - erp_pkg::TWO_PI_Q30;
    else if (z_wide < -erp_pkg::PI_Q30) z_red = z_wide + erp_pkg::TWO_PI_Q30;
    else z_red = z_wide;
  end

  // cordic shifts and final rounding to q1.16
  always_comb begin
    xs = x >>> it;
    ys = y >>> it;
    xf = neg ? -x : x;
    yf = neg ? -y : y;
    cos_r = 20'((xf + 34'sd8192) >>> 14);
    sin_r = 20'((yf + 34'sd8192) >>> 14);
  end

  // multiplier operands and rounded product
  always_comb begin
    us = ucode(step);
    opa = pick(us.a, sx, cx, sy, cy, sz, cz, ta, tg, tj);
    opb = pick(us.b, sx, cx, sy, cy, sz, cz, ta, tg, tj);
    mq = 20'((prod + 36'sd32768) >>> 16);
  end

  assign stat.busy = (state != IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      for (int i = 0; i < 3; i++) ang[i] <= '0;
      for (int i = 0; i < 9; i++) coef[i] <= (i % 4 == 0) ? 18'sd65536 : 18'sd0;
      k <= '0;
    end else if (wr_en && (wr_index == erp_pkg::REG_ANGLE_X ||
                           wr_index == erp_pkg::REG_ANGLE_Y ||
                           wr_index == erp_pkg::REG_ANGLE_Z)) begin
      ang[wr_index] <= wr_data;
      k <= '0;
      state <= LOAD;
    end else begin
      unique case (state)
        IDLE: ;
        LOAD: begin
          z <= z_red;
          state <= FOLD;
        end
        FOLD: begin
          if (z > erp_pkg::HALF_PI_Q30) begin
            z <= z - erp_pkg::PI_Q30;
            neg <= 1'b1;
          end else if (z < -erp_pkg::HALF_PI_Q30) begin
            z <= z + erp_pkg::PI_Q30;
            neg <= 1'b1;
          end else begin
            neg <= 1'b0;
          end
          x <= erp_pkg::GAIN_Q30;
          y <= '0;
          it <= '0;
          state <= ITER;
        end
        ITER: begin
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - erp_pkg::atan_q30(it);
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + erp_pkg::atan_q30(it);
          end
          it <= it + 1'b1;
          if (it == erp_pkg::ITER_W'(erp_pkg::CORDIC_ITERS - 1)) state <= FIN;
        end
        FIN: begin
          unique case (k)
            2'd0: begin sx <= sin_r[17:0]; cx <= cos_r[17:0]; end
            2'd1: begin sy <= sin_r[17:0]; cy <= cos_r[17:0]; end
            default: begin sz <= sin_r[17:0]; cz <= cos_r[17:0]; end
          endcase
          if (k == 2'd2) begin
            step <= '0;
            state <= MUL;
          end else begin
            k <= k + 1'b1;
            state <= LOAD;
          end
        end
        MUL: begin
          prod <= opa * opb;
          state <= WB;
        end
        WB: begin
          unique case (us.op)
            OP_SET: macc[us.dst] <= mq;
            OP_NSET: macc[us.dst] <= -mq;
            OP_ADD: macc[us.dst] <= macc[us.dst] + mq;
            OP_SUB: macc[us.dst] <= macc[us.dst] - mq;
            default: begin
              if (us.dst == 4'd0) ta <= mq[17:0];
              else if (us.dst == 4'd1) tg <= mq[17:0];
              else tj <= mq[17:0];
            end
          endcase
          if (step == LAST_STEP) begin
            state <= SAT;
          end else begin
            step <= step + 1'b1;
            state <= MUL;
          end
        end
        SAT: begin
          // the top right coefficient is sin(y) itself
          for (int i = 0; i < 9; i++) coef[i] <= (i == 2) ? sy : sat_coef(macc[i]);
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // the angle counter only walks the three axes
  a_k_range: assert property (@(posedge clk) disable iff (rst) k != 2'd3)
    else $error("axis counter out of range");
  // products only start after all three axes are done
  a_mul_after_fin: assert property (@(posedge clk) disable iff (rst)
      (state == MUL && $past(state) == FIN) |-> $past(k) == 2'd2)
    else $error("coefficient products started early");
  // a write of a known register restarts the build
  a_restart: assert property (@(posedge clk) disable iff (rst)
      (wr_en && (wr_index == erp_pkg::REG_ANGLE_X || wr_index == erp_pkg::REG_ANGLE_Y ||
                 wr_index == erp_pkg::REG_ANGLE_Z)) |=> state == LOAD && k == 2'd0)
    else $error("angle write did not restart build");

endmodule
`default_nettype wire

FILE: design/erp_front.sv
// input side: point acceptance and two-entry queue toward the matrix pipeline
`default_nettype none
module erp_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire erp_pkg::build_stat_t        stat,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [erp_pkg::POINT_W-1:0] in_data,
  output logic                             q_valid,
  input  wire logic                        q_ready,
  output logic [erp_pkg::POINT_W-1:0]      q_data
);

  logic [erp_pkg::POINT_W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  // points wait while the coefficients are rebuilt
  assign in_ready = (count != 2'd2) && !stat.busy;
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue overflow");
  a_busy_block: assert property (@(posedge clk) disable iff (rst) stat.busy |-> !push)
    else $error("point accepted during coefficient build");
  a_fill: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count mismatch");

endmodule
`default_nettype wire

FILE: design/erp_back.sv
// matrix multiply pipeline: nine products, row sums, rounding and saturation
`default_nettype none
module erp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire erp_pkg::coef_t              coef [9],
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire logic [erp_pkg::POINT_W-1:0] q_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [erp_pkg::POINT_W-1:0]      out_data
);

  logic en;
  logic s1_valid;
  logic signed [49:0] prod [9];
  erp_pkg::coord_t pt [3];
  logic signed [51:0] rsum [3];
  logic signed [35:0] rnd [3];
  erp_pkg::coord_t res [3];

  assign en = !out_valid || out_ready;
  assign q_ready = en;

  // split input coordinates
  always_comb begin
    for (int c = 0; c < 3; c++) pt[c] = q_data[c*erp_pkg::COORD_W +: erp_pkg::COORD_W];
  end

  // row sums, rounding and saturation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = 52'(prod[r*3]) + 52'(prod[r*3+1]) + 52'(prod[r*3+2]) + 52'sd32768;
      rnd[r] = 36'(rsum[r] >>> 16);
      if (rnd[r] > 36'sd2147483647) res[r] = 32'sh7FFFFFFF;
      else if (rnd[r] < -36'sd2147483648) res[r] = 32'sh80000000;
      else res[r] = rnd[r][31:0];
    end
  end

  // product stage and output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) prod[i] <= coef[i] * pt[i % 3];
      out_data <= {res[2], res[1], res[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
      out_valid <= s1_valid;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("product stage lost during stall");
  a_advance: assert property (@(posedge clk) disable iff (rst)
      (s1_valid && en) |=> out_valid)
    else $error("product stage did not reach output");
  a_take: assert property (@(posedge clk) disable iff (rst)
      (q_valid && q_ready) |=> s1_valid)
    else $error("queued point not taken into products");

endmodule
`default_nettype wire
